>>> hw/rtl/ics_pkg.sv
// shared types and constants of the infix calculator stream unit
`default_nettype none

package ics_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned OUT_WIDTH       = 32;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_TIMES  = 8'h2A;
	localparam logic [7:0] CH_DIVIDE = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [1:0] {
		OP_PLUS   = 2'd0,
		OP_MINUS  = 2'd1,
		OP_TIMES  = 2'd2,
		OP_DIVIDE = 2'd3
	} op_t;

	// request to the serial multiply/divide unit
	typedef struct packed {
		logic start;
		logic divide;
	} md_req_t;

	// status back from the serial multiply/divide unit
	typedef struct packed {
		logic done;
		logic div_zero;
	} md_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/ics_char_if.sv
// character input channel: valid/ready handshake with one ascii character
`default_nettype none

interface ics_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ics_res_if.sv
// result output channel: valid/ready handshake with the expression value
`default_nettype none

interface ics_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [ics_pkg::OUT_WIDTH-1:0] value;
	logic                                div_zero;

	modport source (output valid, output value, output div_zero, input ready);
	modport sink (input valid, input value, input div_zero, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ics_muldiv.sv
// bit-serial multiplier and restoring divider, one bit per cycle
`default_nettype none

module ics_muldiv #(
	parameter int unsigned VALUE_WIDTH = ics_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ics_pkg::md_req_t       req,
	input  wire logic [VALUE_WIDTH-1:0] a,
	input  wire logic [VALUE_WIDTH-1:0] b,
	output ics_pkg::md_rsp_t            rsp,
	output logic [VALUE_WIDTH-1:0]      res
);
	import ics_pkg::*;

	localparam int unsigned CW = $clog2(VALUE_WIDTH);
	localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_FIX
	} md_state_t;

	md_state_t              state_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] x_q;
	logic [VALUE_WIDTH-1:0] y_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   done_q;
	logic                   dz_q;

	logic                   a_neg;
	logic                   b_neg;
	logic [VALUE_WIDTH-1:0] a_mag;
	logic [VALUE_WIDTH-1:0] b_mag;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH-1:0] mul_sum;

	assign a_neg   = a[VALUE_WIDTH-1];
	assign b_neg   = b[VALUE_WIDTH-1];
	assign a_mag   = a_neg ? (~a + VALUE_WIDTH'(1)) : a;
	assign b_mag   = b_neg ? (~b + VALUE_WIDTH'(1)) : b;
	assign trial   = {rem_q, x_q[VALUE_WIDTH-1]} - {1'b0, y_q};
	assign mul_sum = acc_q + (y_q[0] ? x_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			dz_q    <= 1'b0;
			acc_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						dz_q  <= 1'b0;
						cnt_q <= '0;
						acc_q <= '0;
						rem_q <= '0;
						if (!req.divide) begin
							x_q     <= a;
							y_q     <= b;
							state_q <= MD_MUL;
						end else if (b == '0) begin
							// zero divisor: quotient is zero, flag it
							dz_q   <= 1'b1;
							done_q <= 1'b1;
						end else begin
							x_q     <= a_mag;
							y_q     <= b_mag;
							neg_q   <= a_neg ^ b_neg;
							state_q <= MD_DIV;
						end
					end
				end
				MD_MUL: begin
					acc_q <= mul_sum;
					x_q   <= {x_q[VALUE_WIDTH-2:0], 1'b0};
					y_q   <= {1'b0, y_q[VALUE_WIDTH-1:1]};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CNT_LAST) begin
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end
				end
				MD_DIV: begin
					x_q   <= {x_q[VALUE_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q + CW'(1);
					if (!trial[VALUE_WIDTH]) begin
						rem_q <= trial[VALUE_WIDTH-1:0];
						acc_q <= {acc_q[VALUE_WIDTH-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[VALUE_WIDTH-2:0], x_q[VALUE_WIDTH-1]};
						acc_q <= {acc_q[VALUE_WIDTH-2:0], 1'b0};
					end
					if (cnt_q == CNT_LAST) begin
						state_q <= MD_FIX;
					end
				end
				MD_FIX: begin
					// restore the sign of the quotient
					if (neg_q) begin
						acc_q <= ~acc_q + VALUE_WIDTH'(1);
					end
					done_q  <= 1'b1;
					state_q <= MD_IDLE;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	assign res          = acc_q;
	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;

endmodule

`default_nettype wire

>>> hw/rtl/infix_calculator_stream_unit.sv
// top level: infix expression evaluator taking one character per item
// a digit or ignored character is taken in the idle state, which keeps the input ready;
// an operator passes the apply state and, with * or / pending, then the wait state
//   (bit-serial multiply/divide unit, one bit per cycle; a zero divisor skips the steps)
// a last item ends in the emit state to load the output register, which then waits for ready
// arst_n clears the sum, term, number, pending operator and flag; reset state is plus
`default_nettype none

module infix_calculator_stream_unit #(
	parameter int unsigned VALUE_WIDTH = ics_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ics_char_if.sink  chars,
	ics_res_if.source results
);
	import ics_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] sum_q;
	logic [VALUE_WIDTH-1:0] term_q;
	logic [VALUE_WIDTH-1:0] cur_q;
	op_t                    op_q;
	op_t                    nxt_op_q;
	logic                   is_op_q;
	logic                   fin_q;
	logic                   zdiv_q;
	logic                   out_valid_q;
	logic [OUT_WIDTH-1:0]   out_value_q;
	logic                   out_dz_q;

	logic                   accept;
	logic                   is_digit;
	logic                   is_op;
	op_t                    ch_op;
	logic [VALUE_WIDTH-1:0] cur_next;
	logic [VALUE_WIDTH-1:0] total;
	logic                   out_free;

	md_req_t                md_req;
	md_rsp_t                md_rsp;
	logic [VALUE_WIDTH-1:0] md_res;

	assign chars.ready = (state_q == ST_IDLE);
	assign accept      = chars.valid && chars.ready;

	always_comb begin
		is_digit = (chars.ch >= CH_ZERO) && (chars.ch <= CH_NINE);
		is_op    = 1'b1;
		case (chars.ch)
			CH_PLUS:   ch_op = OP_PLUS;
			CH_MINUS:  ch_op = OP_MINUS;
			CH_TIMES:  ch_op = OP_TIMES;
			CH_DIVIDE: ch_op = OP_DIVIDE;
			default: begin
				ch_op = OP_PLUS;
				is_op = 1'b0;
			end
		endcase
	end

	// times ten as two shifts, plus the digit
	assign cur_next = {cur_q[VALUE_WIDTH-4:0], 3'b000} + {cur_q[VALUE_WIDTH-2:0], 1'b0}
		+ VALUE_WIDTH'(chars.ch[3:0]);

	assign total    = sum_q + term_q;
	assign out_free = !out_valid_q || results.ready;

	assign md_req.start  = (state_q == ST_APPLY) && ((op_q == OP_TIMES) || (op_q == OP_DIVIDE));
	assign md_req.divide = (op_q == OP_DIVIDE);

	ics_muldiv #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.a     (term_q),
		.b     (cur_q),
		.rsp   (md_rsp),
		.res   (md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			term_q      <= '0;
			cur_q       <= '0;
			op_q        <= OP_PLUS;
			nxt_op_q    <= OP_PLUS;
			is_op_q     <= 1'b0;
			fin_q       <= 1'b0;
			zdiv_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_dz_q    <= 1'b0;
		end else begin
			// the emit state reloads the output register itself
			if (out_valid_q && results.ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_digit) begin
							cur_q <= cur_next;
						end
						nxt_op_q <= ch_op;
						is_op_q  <= is_op;
						fin_q    <= chars.last;
						if (is_op || chars.last) begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					case (op_q)
						OP_PLUS: begin
							sum_q  <= total;
							term_q <= cur_q;
						end
						OP_MINUS: begin
							sum_q  <= total;
							term_q <= ~cur_q + VALUE_WIDTH'(1);
						end
						default: begin
						end
					endcase
					if (is_op_q) begin
						op_q <= nxt_op_q;
					end
					cur_q <= '0;
					if ((op_q == OP_TIMES) || (op_q == OP_DIVIDE)) begin
						state_q <= ST_WAIT;
					end else if (fin_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WAIT: begin
					if (md_rsp.done) begin
						term_q  <= md_res;
						zdiv_q  <= zdiv_q | md_rsp.div_zero;
						state_q <= fin_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_value_q <= OUT_WIDTH'($signed(total));
						out_dz_q    <= zdiv_q;
						out_valid_q <= 1'b1;
						sum_q       <= '0;
						term_q      <= '0;
						cur_q       <= '0;
						op_q        <= OP_PLUS;
						zdiv_q      <= 1'b0;
						fin_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid    = out_valid_q;
	assign results.value    = out_value_q;
	assign results.div_zero = out_dz_q;

endmodule

`default_nettype wire

>>> hw/rtl/ics_checker.sv
// port-level checks of the infix calculator stream unit, bound to the top level
`default_nettype none

module ics_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [7:0]  in_ch,
	input wire logic        in_last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_value,
	input wire logic        out_div_zero
);
	import ics_pkg::*;

	logic in_acc;
	logic acc_op;
	logic acc_digit;

	assign in_acc    = in_valid && in_ready;
	assign acc_op    = in_acc && ((in_ch == CH_PLUS) || (in_ch == CH_MINUS)
		|| (in_ch == CH_TIMES) || (in_ch == CH_DIVIDE));
	assign acc_digit = in_acc && (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);

	// a waiting result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_div_zero))
		else $error("result changed while stalled");

	// an operator is always applied in the apply state, with ready low
	a_op_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_op |=> !in_ready)
		else $error("ready right after an operator item");

	// closing an expression always passes the apply state, with ready low
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |=> !in_ready)
		else $error("ready right after a last item");

	// a plain digit inside an expression leaves the input ready
	a_digit_fast: assert property (@(posedge clk) disable iff (!arst_n)
		acc_digit && !in_last |=> in_ready)
		else $error("digit item stalled the input");

endmodule

bind infix_calculator_stream_unit ics_checker u_ics_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (chars.valid),
	.in_ready    (chars.ready),
	.in_ch       (chars.ch),
	.in_last     (chars.last),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_value   (results.value),
	.out_div_zero(results.div_zero)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench of the infix calculator stream unit: character stream driver, result monitor, predictor
`timescale 1ns / 100ps

module testbench;
	import ics_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int DRAIN_CYCLES = 48;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] value;
		logic                        div_zero;
	} calc_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ics_char_if chars_if ();
	ics_res_if  res_if ();

	infix_calculator_stream_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_item_t   pending_chars[$];
	calc_result_t expected_results[$];

	int  queued_items;
	int  counted_items;
	int  accepted_items;
	int  checked_results;
	int  error_count;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  char_taken;

	// predictor state
	logic [31:0] calc_sum;
	logic [31:0] calc_term;
	logic [31:0] calc_num;
	op_t         calc_op;
	logic        calc_dz;

	task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
		$display("mismatch: %s expected %0d got %0d (result %0d)", what, exp_v, got_v,
			checked_results);
		error_count++;
	endtask

	function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	task automatic clear_calc();
		calc_sum  = '0;
		calc_term = '0;
		calc_num  = '0;
		calc_op   = OP_PLUS;
		calc_dz   = 1'b0;
	endtask

	task automatic evaluate_char(input logic [7:0] c, input logic fin);
		bit           is_op;
		op_t          op;
		calc_result_t r;
		is_op = 1'b0;
		op = OP_PLUS;
		if (c >= CH_ZERO && c <= CH_NINE)
			calc_num = calc_num * 32'd10 + 32'(c - CH_ZERO);
		case (c)
			CH_PLUS: begin
				is_op = 1'b1;
				op = OP_PLUS;
			end
			CH_MINUS: begin
				is_op = 1'b1;
				op = OP_MINUS;
			end
			CH_TIMES: begin
				is_op = 1'b1;
				op = OP_TIMES;
			end
			CH_DIVIDE: begin
				is_op = 1'b1;
				op = OP_DIVIDE;
			end
			default: ;
		endcase
		if (is_op || fin) begin
			case (calc_op)
				OP_PLUS: begin
					calc_sum = calc_sum + calc_term;
					calc_term = calc_num;
				end
				OP_MINUS: begin
					calc_sum = calc_sum + calc_term;
					calc_term = -calc_num;
				end
				OP_TIMES: calc_term = calc_term * calc_num;
				default: begin
					if (calc_num == '0) begin
						calc_term = '0;
						calc_dz = 1'b1;
					end else begin
						calc_term = trunc_div(calc_term, calc_num);
					end
				end
			endcase
			if (is_op)
				calc_op = op;
			calc_num = '0;
		end
		if (fin) begin
			r.value = calc_sum + calc_term;
			r.div_zero = calc_dz;
			expected_results.push_back(r);
			clear_calc();
		end
	endtask

	function automatic bit is_active(input logic [7:0] c, input logic fin);
		return fin || (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS
			|| c == CH_TIMES || c == CH_DIVIDE;
	endfunction

	task automatic push_item(input logic [7:0] c, input logic fin);
		char_item_t it;
		it.ch = c;
		it.last = fin;
		pending_chars.push_back(it);
		queued_items++;
		if (is_active(c, fin))
			counted_items++;
	endtask

	task automatic push_string(input string s);
		for (int k = 0; k < s.len(); k++)
			push_item(s[k], k == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_op();
		case ($urandom_range(3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_TIMES;
			default: return CH_DIVIDE;
		endcase
	endfunction

	// mostly well-formed expressions; some noise bytes, doubled or trailing operators
	task automatic queue_expression();
		logic [7:0] text[$];
		logic [7:0] op;
		int         nterms;
		int         ndig;
		int         roll;
		op = CH_PLUS;
		nterms = $urandom_range(1, 5);
		for (int t = 0; t < nterms; t++) begin
			if (t > 0 || $urandom_range(9) == 0) begin
				op = pick_op();
				text.push_back(op);
				if ($urandom_range(19) == 0)
					text.push_back(pick_op());
			end
			if ($urandom_range(6) == 0)
				text.push_back(" ");
			roll = $urandom_range(99);
			if (op == CH_DIVIDE && roll < 20) begin
				text.push_back(CH_ZERO);
			end else begin
				if (roll < 60)
					ndig = $urandom_range(1, 2);
				else if (roll < 90)
					ndig = $urandom_range(3, 5);
				else
					ndig = $urandom_range(6, 11);
				for (int d = 0; d < ndig; d++)
					text.push_back(CH_ZERO + 8'($urandom_range(9)));
			end
			if ($urandom_range(19) == 0)
				text.push_back(8'($urandom_range(255)));
			if ($urandom_range(7) == 0)
				text.push_back(" ");
		end
		roll = $urandom_range(19);
		if (roll < 2)
			text.push_back(pick_op());
		else if (roll < 4)
			text.push_back(8'($urandom_range(255)));
		for (int k = 0; k < text.size(); k++)
			push_item(text[k], k == text.size() - 1);
	endtask

	// driver: new item at the falling edge once the previous one has been taken
	always @(negedge clk) begin : drive_chars
		char_item_t it;
		if (arst_n) begin
			if (!chars_if.valid || char_taken) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = pending_chars.pop_front();
					chars_if.valid <= 1'b1;
					chars_if.ch <= it.ch;
					chars_if.last <= it.last;
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
			char_taken = 1'b0;
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on accepted characters, check accepted results
	always @(posedge clk) begin : watch
		calc_result_t exp_r;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected, value", 0, res_if.value);
				end else begin
					exp_r = expected_results.pop_front();
					if (res_if.value !== exp_r.value)
						report_mismatch("value", exp_r.value, res_if.value);
					if (res_if.div_zero !== exp_r.div_zero)
						report_mismatch("div_zero", exp_r.div_zero, res_if.div_zero);
				end
				checked_results++;
			end
			if (chars_if.valid && chars_if.ready) begin
				evaluate_char(chars_if.ch, chars_if.last);
				accepted_items++;
				char_taken = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int target;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch = '0;
		chars_if.last = 1'b0;
		res_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clear_calc();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: digit overflow to -1 and the most negative value over it
		push_string("2147483648/4294967295");
		// leading minus, times, last item an operator
		push_string("-9*0/");
		// division by zero, then an ignored code closing the expression
		push_item("8", 1'b0);
		push_item(CH_DIVIDE, 1'b0);
		push_item(CH_ZERO, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(8'h00, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 47;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 47;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			target = counted_items + RANDOM_ITEMS / 4;
			while (counted_items < target)
				queue_expression();
			while (accepted_items != queued_items || expected_results.size() != 0)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered, count", 0, expected_results.size());
		$display("summary: %0d characters accepted, %0d expressions evaluated and checked",
			accepted_items, checked_results);
		$display("summary: four handshake phases, free-running to both sides stalling");
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
